[rtl/mac_ip_binding_guard_core_assert.svh]
// assertion macros for the binding guard checker
// no dependencies
`ifndef MAC_IP_BINDING_GUARD_CORE_ASSERT_SVH
`define MAC_IP_BINDING_GUARD_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MIBG_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("binding guard check failed");
// next-cycle implication
`define MIBG_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("binding guard check failed");
`endif

[rtl/mibg_pkg.sv]
// shared codes for the mac/ip binding guard
// no dependencies
package mibg_pkg;
    localparam logic [1:0] ACT_MATCH   = 2'd0;
    localparam logic [1:0] ACT_PROT_IP = 2'd1;
    localparam logic [1:0] ACT_PROT_MAC = 2'd2;
    localparam logic [1:0] ACT_PROT_PAIR = 2'd3;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
endpackage

[rtl/mac_ip_binding_guard_core.sv]
// mac/ip binding guard: protected address table with match and learn
// depends on mibg_pkg
// timing: each entry walked takes a registered read, then a compare; the end-of-table
//   check also waits for a read; inserts pass through a status state before the result
// flow: one request at a time, next accept in the cycle after the result transfer;
//   the walk uses one shared compare unit and the result register must drain first
// reset: synchronous active-low aresetn clears valid bits, entry count and control
// state; address stores are not cleared and are only read behind valid bits
module mac_ip_binding_guard_core
    import mibg_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: mac[47:0], ip_high[111:48], ip_low[175:112]
    input  logic [175:0] s_tdata,
    // tuser: action[1:0], ip_kind[2]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[1:0], conflict[2], conflict_index[6:3], learned[7]
    output logic [7:0]   m_tdata
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // address stores, read one entry a cycle at the walk pointer
    logic [47:0] mac_store [TABLE_DEPTH];
    logic [31:0] v4_store  [TABLE_DEPTH];
    logic [63:0] v6h_store [TABLE_DEPTH];
    logic [63:0] v6l_store [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] mac_vld_reg, v4_vld_reg, v6_vld_reg;
    logic [CW-1:0] count_reg;

    logic [1:0]  state_reg;
    logic [1:0]  act_reg;
    logic        kind_reg;
    logic [47:0] mac_reg;
    logic [63:0] hi_reg, lo_reg;
    logic [CW-1:0] ptr_reg;
    logic        found_reg;         // pairing: mac already present
    logic [IW-1:0] slot_reg;
    logic        dup_reg;
    logic [7:0]  out_reg;

    // registered read of the entry at the pointer
    logic [47:0] rd_mac;
    logic [31:0] rd_v4;
    logic [63:0] rd_v6h, rd_v6l;
    logic        rd_ok;             // read data belongs to current pointer
    logic [IW-1:0] rd_idx;

    logic [IW-1:0] ptr_idx;
    assign ptr_idx = ptr_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        rd_mac <= mac_store[ptr_idx];
        rd_v4  <= v4_store[ptr_idx];
        rd_v6h <= v6h_store[ptr_idx];
        rd_v6l <= v6l_store[ptr_idx];
        rd_idx <= ptr_idx;
    end

    // shared compare unit on the registered entry
    logic mv, ipset, mac_eq, ip_eq;
    always_comb begin
        mv     = mac_vld_reg[rd_idx];
        ipset  = kind_reg ? v6_vld_reg[rd_idx] : v4_vld_reg[rd_idx];
        mac_eq = mv && (rd_mac == mac_reg);
        ip_eq  = ipset && (kind_reg ? (rd_v6h == hi_reg && rd_v6l == lo_reg)
                                    : (rd_v4 == lo_reg[31:0]));
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = out_reg;

    logic walk_end;
    assign walk_end = (ptr_reg >= count_reg);

    // write port: one entry per request
    logic         wr_mac, wr_ip;
    logic [IW-1:0] wr_idx;
    logic         alloc;

    always_ff @(posedge aclk) begin
        if (wr_mac) mac_store[wr_idx] <= mac_reg;
        if (wr_ip && !kind_reg) v4_store[wr_idx] <= lo_reg[31:0];
        if (wr_ip && kind_reg) begin
            v6h_store[wr_idx] <= hi_reg;
            v6l_store[wr_idx] <= lo_reg;
        end
    end

    always_comb begin
        wr_mac = 1'b0;
        wr_ip  = 1'b0;
        alloc  = 1'b0;
        wr_idx = slot_reg;
        if (state_reg == S_WALK && rd_ok && !walk_end && act_reg == ACT_MATCH) begin
            wr_idx = rd_idx;
            if (mac_eq && !ipset) wr_ip = 1'b1;
            else if (!mac_eq && ip_eq && !mv) wr_mac = 1'b1;
        end else if (state_reg == S_DONE && !dup_reg) begin
            wr_idx = (act_reg == ACT_PROT_PAIR && found_reg) ? slot_reg
                                                              : count_reg[IW-1:0];
            unique case (act_reg)
                ACT_PROT_IP: begin
                    alloc = (count_reg < CW'(TABLE_DEPTH));
                    wr_ip = alloc;
                end
                ACT_PROT_MAC: begin
                    alloc  = (count_reg < CW'(TABLE_DEPTH));
                    wr_mac = alloc;
                end
                ACT_PROT_PAIR: begin
                    if (found_reg) begin
                        wr_ip = 1'b1;
                    end else begin
                        alloc  = (count_reg < CW'(TABLE_DEPTH));
                        wr_mac = alloc;
                        wr_ip  = alloc;
                    end
                end
                default: ;
            endcase
        end
    end

    logic [TABLE_DEPTH-1:0] sel;
    assign sel = TABLE_DEPTH'(1) << wr_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mac_vld_reg <= '0;
            v4_vld_reg  <= '0;
            v6_vld_reg  <= '0;
            count_reg   <= '0;
            rd_ok       <= 1'b0;
        end else begin
            if (alloc) begin
                // fresh entry starts with all addresses unset
                mac_vld_reg <= (mac_vld_reg & ~sel) | (wr_mac ? sel : '0);
                v4_vld_reg  <= (v4_vld_reg & ~sel) | ((wr_ip && !kind_reg) ? sel : '0);
                v6_vld_reg  <= (v6_vld_reg & ~sel) | ((wr_ip && kind_reg) ? sel : '0);
                count_reg   <= count_reg + CW'(1);
            end else begin
                if (wr_mac) mac_vld_reg <= mac_vld_reg | sel;
                if (wr_ip && !kind_reg) v4_vld_reg <= v4_vld_reg | sel;
                if (wr_ip && kind_reg) v6_vld_reg <= v6_vld_reg | sel;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        act_reg   <= s_tuser[1:0];
                        kind_reg  <= s_tuser[2];
                        mac_reg   <= s_tdata[47:0];
                        hi_reg    <= s_tdata[111:48];
                        lo_reg    <= s_tdata[175:112];
                        ptr_reg   <= '0;
                        found_reg <= 1'b0;
                        dup_reg   <= 1'b0;
                        slot_reg  <= '0;
                        out_reg   <= '0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK: begin
                    // a new pointer's registered read must land before it is compared
                    rd_ok <= !rd_ok;
                    if (rd_ok && walk_end) begin
                        state_reg <= (act_reg == ACT_MATCH) ? S_OUT : S_DONE;
                    end else if (rd_ok) begin
                        // default: move on to the next entry
                        ptr_reg <= ptr_reg + CW'(1);
                        unique case (act_reg)
                            ACT_MATCH: begin
                                if (mac_eq) begin
                                    if (!ipset) begin
                                        out_reg[7] <= 1'b1;
                                        state_reg  <= S_OUT;
                                    end else if (!ip_eq) begin
                                        out_reg[2]   <= 1'b1;
                                        out_reg[6:3] <= 4'(rd_idx);
                                        state_reg    <= S_OUT;
                                    end
                                end else if (ip_eq) begin
                                    if (!mv) begin
                                        out_reg[7] <= 1'b1;
                                        state_reg  <= S_OUT;
                                    end else begin
                                        out_reg[2]   <= 1'b1;
                                        out_reg[6:3] <= 4'(rd_idx);
                                        state_reg    <= S_OUT;
                                    end
                                end
                            end
                            ACT_PROT_IP: begin
                                if (ip_eq) begin
                                    dup_reg   <= 1'b1;
                                    state_reg <= S_DONE;
                                end
                            end
                            ACT_PROT_MAC: begin
                                if (mac_eq) begin
                                    dup_reg   <= 1'b1;
                                    state_reg <= S_DONE;
                                end
                            end
                            ACT_PROT_PAIR: begin
                                if (mac_eq) begin
                                    found_reg <= 1'b1;
                                    slot_reg  <= rd_idx;
                                    dup_reg   <= ipset;
                                    state_reg <= S_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DONE: begin
                    if (dup_reg) out_reg[1:0] <= ST_DUP;
                    else if (!(act_reg == ACT_PROT_PAIR && found_reg) &&
                             count_reg >= CW'(TABLE_DEPTH)) out_reg[1:0] <= ST_FULL;
                    else out_reg[1:0] <= ST_OK;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/mibg_checker.sv]
// port-level checker for the binding guard, bound to the top level
// depends on mac_ip_binding_guard_core_assert.svh
`include "mac_ip_binding_guard_core_assert.svh"
module mibg_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    // one request in flight: no input while a result waits
    `MIBG_ASSERT_IMP(a_excl, aclk, aresetn, m_tvalid, !s_tready)
    // an accepted request blocks the input on the next cycle
    `MIBG_ASSERT_NXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready && !m_tvalid)
    // status never reports a reserved code
    `MIBG_ASSERT_IMP(a_stat, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3)
    // a conflict is reported only with ok status and without learning
    `MIBG_ASSERT_IMP(a_conf, aclk, aresetn, m_tvalid && m_tdata[2],
                     m_tdata[1:0] == 2'd0 && !m_tdata[7])
    // a stalled result stays put
    `MIBG_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))
endmodule

bind mac_ip_binding_guard_core mibg_checker u_mibg_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
